/* design/ptpm_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the endpoint table pick and match block.
// No dependencies.
package ptpm_pkg;

	localparam int TABLE_DEPTH = 16;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int FIELD_CNT_W = 5;
	localparam int CMP_W       = (CNT_W > FIELD_CNT_W) ? CNT_W : FIELD_CNT_W;
	localparam int INDEX_W     = 4;
	localparam int ADDR_W      = 32;
	localparam int PORT_W      = 16;
	localparam int CTR_W       = 32;
	localparam int BITCNT_W    = $clog2(CTR_W);
	localparam int ENTRY_W     = ADDR_W + PORT_W;
	localparam int REG_IDX_W   = 3;

	localparam logic [1:0] FUNC_WRITE = 2'd0;
	localparam logic [1:0] FUNC_PICK  = 2'd1;
	localparam logic [1:0] FUNC_MATCH = 2'd2;

	localparam logic [1:0] MODE_ROUND  = 2'd0;
	localparam logic [1:0] MODE_RANDOM = 2'd1;
	localparam logic [1:0] MODE_MANUAL = 2'd2;

	localparam logic [REG_IDX_W-1:0] REG_LIST_ENABLE  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_PICK_MODE    = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_MANUAL_INDEX = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_ENTRY_COUNT  = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_SINGLE_VALID = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_SINGLE_ADDR  = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_SINGLE_PORT  = 3'd6;

	typedef struct packed {
		logic                   list_enable;
		logic [1:0]             pick_mode;
		logic [INDEX_W-1:0]     manual_index;
		logic [FIELD_CNT_W-1:0] entry_count;
		logic                   single_valid;
		logic [ADDR_W-1:0]      single_address;
		logic [PORT_W-1:0]      single_port;
	} cfg_t;

	typedef struct packed {
		logic [ADDR_W-1:0] address;
		logic [PORT_W-1:0] port;
	} entry_t;

	typedef struct packed {
		logic               found;
		logic               from_single;
		logic [INDEX_W-1:0] index;
		logic [ADDR_W-1:0]  address;
		logic [PORT_W-1:0]  port;
	} res_t;

endpackage

/* design/proxy_table_pick_and_match.sv */
`timescale 1ns / 1ps
// A write gives no result. A manual pick hit passes S_PICK, S_READ and S_DONE, and a pick that
// uses only the single endpoint passes S_PICK, S_SINGLE and S_DONE; a scanned pick runs the
// bit-serial start modulo in S_MOD, then the ring scan in S_SCAN, then S_READ or S_SINGLE; a
// match ends on a fallback hit, else sweeps the entries in use in S_MREQ and S_MCMP. One item
// is worked at a time. Reset clears the registers, the entry valid flags and the rotation
// counter; the entry RAM is not cleared, and needs no clearing pass.
module proxy_table_pick_and_match (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [4:0]                   paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [1:0]                   func,
	input  logic [ptpm_pkg::INDEX_W-1:0] write_index,
	input  logic                         write_valid,
	input  logic [ptpm_pkg::ADDR_W-1:0]  write_address,
	input  logic [ptpm_pkg::PORT_W-1:0]  write_port,
	input  logic [ptpm_pkg::CTR_W-1:0]   random_start,
	input  logic [ptpm_pkg::ADDR_W-1:0]  query_address,
	input  logic [ptpm_pkg::PORT_W-1:0]  query_port,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         found,
	output logic                         from_single,
	output logic [ptpm_pkg::INDEX_W-1:0] chosen_index,
	output logic [ptpm_pkg::ADDR_W-1:0]  chosen_address,
	output logic [ptpm_pkg::PORT_W-1:0]  chosen_port
);

	ptpm_pkg::cfg_t                    cfg_q;
	ptpm_pkg::res_t                    result;
	logic                              cfg_we;
	logic [ptpm_pkg::REG_IDX_W-1:0]    reg_idx;

	assign pready  = 1'b1;
	assign cfg_we  = psel && penable && pwrite && pready;
	assign reg_idx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (reg_idx)
				ptpm_pkg::REG_LIST_ENABLE:  cfg_q.list_enable    <= pwdata[0];
				ptpm_pkg::REG_PICK_MODE:    cfg_q.pick_mode      <= pwdata[1:0];
				ptpm_pkg::REG_MANUAL_INDEX: cfg_q.manual_index   <= pwdata[3:0];
				ptpm_pkg::REG_ENTRY_COUNT:  cfg_q.entry_count    <= pwdata[4:0];
				ptpm_pkg::REG_SINGLE_VALID: cfg_q.single_valid   <= pwdata[0];
				ptpm_pkg::REG_SINGLE_ADDR:  cfg_q.single_address <= pwdata;
				ptpm_pkg::REG_SINGLE_PORT:  cfg_q.single_port    <= pwdata[15:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			ptpm_pkg::REG_LIST_ENABLE:  prdata = 32'(cfg_q.list_enable);
			ptpm_pkg::REG_PICK_MODE:    prdata = 32'(cfg_q.pick_mode);
			ptpm_pkg::REG_MANUAL_INDEX: prdata = 32'(cfg_q.manual_index);
			ptpm_pkg::REG_ENTRY_COUNT:  prdata = 32'(cfg_q.entry_count);
			ptpm_pkg::REG_SINGLE_VALID: prdata = 32'(cfg_q.single_valid);
			ptpm_pkg::REG_SINGLE_ADDR:  prdata = cfg_q.single_address;
			ptpm_pkg::REG_SINGLE_PORT:  prdata = 32'(cfg_q.single_port);
			default:                    prdata = '0;
		endcase
	end

	ptpm_engine u_engine (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.func          (func),
		.write_index   (write_index),
		.write_valid   (write_valid),
		.write_address (write_address),
		.write_port    (write_port),
		.random_start  (random_start),
		.query_address (query_address),
		.query_port    (query_port),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.result        (result)
	);

	assign found          = result.found;
	assign from_single    = result.from_single;
	assign chosen_index   = result.index;
	assign chosen_address = result.address;
	assign chosen_port    = result.port;

endmodule

/* design/ptpm_entry_ram.sv */
`timescale 1ns / 1ps
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module ptpm_entry_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 48,
	parameter int AW    = 4
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* design/ptpm_engine.sv */
`timescale 1ns / 1ps
// Item sequencer: entry writes, bit-serial start modulo, ring scan, match sweep.
// Depends on ptpm_pkg and ptpm_entry_ram.
module ptpm_engine (
	input  logic                            clk,
	input  logic                            arst_n,
	input  ptpm_pkg::cfg_t                  cfg,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [1:0]                      func,
	input  logic [ptpm_pkg::INDEX_W-1:0]    write_index,
	input  logic                            write_valid,
	input  logic [ptpm_pkg::ADDR_W-1:0]     write_address,
	input  logic [ptpm_pkg::PORT_W-1:0]     write_port,
	input  logic [ptpm_pkg::CTR_W-1:0]      random_start,
	input  logic [ptpm_pkg::ADDR_W-1:0]     query_address,
	input  logic [ptpm_pkg::PORT_W-1:0]     query_port,
	output logic                            out_valid,
	input  logic                            out_stall,
	output ptpm_pkg::res_t                  result
);

	typedef enum logic [3:0] {
		S_IDLE, S_PICK, S_MOD, S_SCAN, S_READ, S_SINGLE, S_MATCH, S_MREQ, S_MCMP, S_DONE
	} state_t;

	state_t                                state_q;
	logic [ptpm_pkg::TABLE_DEPTH-1:0]      valid_q;
	logic [ptpm_pkg::CTR_W-1:0]            rot_q;
	logic [ptpm_pkg::CTR_W-1:0]            pos_q;
	logic [ptpm_pkg::CTR_W-1:0]            div_q;
	logic [ptpm_pkg::BITCNT_W-1:0]         bit_q;
	logic [ptpm_pkg::IDX_W-1:0]            rem_q;
	logic [ptpm_pkg::IDX_W-1:0]            slot_q;
	logic [ptpm_pkg::CNT_W-1:0]            scan_n_q;
	logic [ptpm_pkg::CNT_W-1:0]            mcnt_q;
	logic [ptpm_pkg::CTR_W-1:0]            rand_q;
	logic [ptpm_pkg::ADDR_W-1:0]           qaddr_q;
	logic [ptpm_pkg::PORT_W-1:0]           qport_q;
	ptpm_pkg::res_t                        res_q;
	ptpm_pkg::res_t                        out_q;
	logic                                  out_valid_q;

	logic                                  accept;
	logic [ptpm_pkg::CNT_W-1:0]            cnt;
	logic [ptpm_pkg::IDX_W:0]              cnt_w;
	logic                                  write_hit;
	logic                                  manual_hit;
	logic [ptpm_pkg::IDX_W-1:0]            manual_slot;
	logic [ptpm_pkg::IDX_W:0]              rem_shift;
	logic [ptpm_pkg::IDX_W-1:0]            rem_next;
	logic [ptpm_pkg::IDX_W:0]              slot_plus;
	logic [ptpm_pkg::IDX_W-1:0]            slot_next;
	logic [ptpm_pkg::CTR_W-1:0]            start;
	logic                                  out_free;
	logic                                  ram_we;
	logic                                  ram_re;
	logic [ptpm_pkg::IDX_W-1:0]            ram_raddr;
	ptpm_pkg::entry_t                      ram_wdata;
	ptpm_pkg::entry_t                      ram_rdata;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);
	assign out_free = !out_valid_q || !out_stall;

	assign cnt = (ptpm_pkg::CMP_W'(cfg.entry_count) > ptpm_pkg::CMP_W'(ptpm_pkg::TABLE_DEPTH))
		? ptpm_pkg::CNT_W'(ptpm_pkg::TABLE_DEPTH) : ptpm_pkg::CNT_W'(cfg.entry_count);
	assign cnt_w = (ptpm_pkg::IDX_W + 1)'(cnt);

	assign write_hit = accept && (func == ptpm_pkg::FUNC_WRITE)
		&& (ptpm_pkg::CMP_W'(write_index) < ptpm_pkg::CMP_W'(ptpm_pkg::TABLE_DEPTH));

	assign manual_slot = ptpm_pkg::IDX_W'(cfg.manual_index);
	assign manual_hit  = (cfg.pick_mode == ptpm_pkg::MODE_MANUAL)
		&& (ptpm_pkg::CMP_W'(cfg.manual_index) < ptpm_pkg::CMP_W'(cnt))
		&& valid_q[manual_slot];

	assign start = (cfg.pick_mode == ptpm_pkg::MODE_RANDOM) ? rand_q : rot_q + 1'b1;

	assign rem_shift = {rem_q, div_q[ptpm_pkg::CTR_W-1]};
	assign rem_next  = (rem_shift >= cnt_w) ? ptpm_pkg::IDX_W'(rem_shift - cnt_w)
		: ptpm_pkg::IDX_W'(rem_shift);

	assign slot_plus = (ptpm_pkg::IDX_W + 1)'(slot_q) + 1'b1;
	assign slot_next = (pos_q == '1 || slot_plus == cnt_w) ? '0 : ptpm_pkg::IDX_W'(slot_plus);

	assign ram_we    = write_hit;
	assign ram_wdata = '{address: write_address, port: write_port};

	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = slot_q;
		case (state_q)
			S_PICK: begin
				ram_re    = manual_hit;
				ram_raddr = manual_slot;
			end
			S_SCAN: begin
				ram_re    = valid_q[slot_q];
				ram_raddr = slot_q;
			end
			S_MREQ: begin
				ram_re    = (mcnt_q != cnt);
				ram_raddr = ptpm_pkg::IDX_W'(mcnt_q);
			end
			default: begin
				ram_re = 1'b0;
			end
		endcase
	end

	ptpm_entry_ram #(
		.DEPTH (ptpm_pkg::TABLE_DEPTH),
		.WIDTH (ptpm_pkg::ENTRY_W),
		.AW    (ptpm_pkg::IDX_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ptpm_pkg::IDX_W'(write_index)),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			valid_q     <= '0;
			rot_q       <= '0;
			pos_q       <= '0;
			div_q       <= '0;
			bit_q       <= '0;
			rem_q       <= '0;
			slot_q      <= '0;
			scan_n_q    <= '0;
			mcnt_q      <= '0;
			rand_q      <= '0;
			qaddr_q     <= '0;
			qport_q     <= '0;
			res_q       <= '0;
			out_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (write_hit) begin
						valid_q[ptpm_pkg::IDX_W'(write_index)] <= write_valid;
					end
					if (accept && func == ptpm_pkg::FUNC_PICK) begin
						rand_q  <= random_start;
						state_q <= S_PICK;
					end
					if (accept && func == ptpm_pkg::FUNC_MATCH) begin
						qaddr_q <= query_address;
						qport_q <= query_port;
						mcnt_q  <= '0;
						state_q <= S_MATCH;
					end
				end
				S_PICK: begin
					if (cfg.list_enable && cnt != '0) begin
						if (manual_hit) begin
							slot_q  <= manual_slot;
							state_q <= S_READ;
						end else begin
							if (cfg.pick_mode != ptpm_pkg::MODE_RANDOM) begin
								rot_q <= start;
							end
							pos_q   <= start;
							div_q   <= start;
							rem_q   <= '0;
							bit_q   <= ptpm_pkg::BITCNT_W'(ptpm_pkg::CTR_W - 1);
							state_q <= S_MOD;
						end
					end else begin
						state_q <= S_SINGLE;
					end
				end
				S_MOD: begin
					rem_q <= rem_next;
					div_q <= div_q << 1;
					bit_q <= bit_q - 1'b1;
					if (bit_q == '0) begin
						slot_q   <= rem_next;
						scan_n_q <= '0;
						state_q  <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (valid_q[slot_q]) begin
						state_q <= S_READ;
					end else if (scan_n_q == cnt - 1'b1) begin
						state_q <= S_SINGLE;
					end else begin
						scan_n_q <= scan_n_q + 1'b1;
						pos_q    <= pos_q + 1'b1;
						slot_q   <= slot_next;
					end
				end
				S_READ: begin
					res_q   <= '{found: 1'b1, from_single: 1'b0,
						index: ptpm_pkg::INDEX_W'(slot_q),
						address: ram_rdata.address, port: ram_rdata.port};
					state_q <= S_DONE;
				end
				S_SINGLE: begin
					if (cfg.single_valid) begin
						res_q <= '{found: 1'b1, from_single: 1'b1, index: '0,
							address: cfg.single_address, port: cfg.single_port};
					end else begin
						res_q <= '0;
					end
					state_q <= S_DONE;
				end
				S_MATCH: begin
					if (cfg.single_valid && qaddr_q == cfg.single_address
						&& qport_q == cfg.single_port) begin
						res_q   <= '{found: 1'b1, default: '0};
						state_q <= S_DONE;
					end else begin
						res_q   <= '0;
						state_q <= S_MREQ;
					end
				end
				S_MREQ: begin
					if (mcnt_q == cnt) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_MCMP;
					end
				end
				S_MCMP: begin
					if (valid_q[ptpm_pkg::IDX_W'(mcnt_q)] && ram_rdata.address == qaddr_q
						&& ram_rdata.port == qport_q) begin
						res_q.found <= 1'b1;
						state_q     <= S_DONE;
					end else begin
						mcnt_q  <= mcnt_q + 1'b1;
						state_q <= S_MREQ;
					end
				end
				S_DONE: begin
					if (out_free) begin
						out_q   <= res_q;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign result    = out_q;

endmodule

/* design/ptpm_checker.sv */
`timescale 1ns / 1ps
// Port-level checker for the endpoint table block, bound to the top level.
// Depends on ptpm_pkg and proxy_table_pick_and_match.
module ptpm_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_stall,
	input logic [1:0]                   func,
	input logic                         out_valid,
	input logic                         out_stall,
	input logic                         found,
	input logic                         from_single,
	input logic [ptpm_pkg::INDEX_W-1:0] chosen_index,
	input logic [ptpm_pkg::ADDR_W-1:0]  chosen_address,
	input logic [ptpm_pkg::PORT_W-1:0]  chosen_port
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(found) && $stable(chosen_address)
			&& $stable(chosen_port))
		else $error("result transaction changed while stalled");

	a_write_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && func == ptpm_pkg::FUNC_WRITE |=> !in_stall)
		else $error("entry write blocked the input");

	a_work_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (func == ptpm_pkg::FUNC_PICK || func == ptpm_pkg::FUNC_MATCH)
			|=> in_stall)
		else $error("input taken while a pick or match is in progress");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> !from_single && chosen_index == '0 && chosen_address == '0
			&& chosen_port == '0)
		else $error("miss result carries endpoint data");

	a_single_found: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && from_single |-> found && chosen_index == '0)
		else $error("fallback result malformed");

endmodule

bind proxy_table_pick_and_match ptpm_checker u_ptpm_checker (.*);
